[sv/kcm_pkg.sv]
// ---------------------------------------------------------------------------
// kcm_pkg
// shared widths, codes and the chord table entry layout of the key chord
// matcher
// ---------------------------------------------------------------------------
package kcm_pkg;

    // default sizes handed to the top level parameters
    localparam int NUM_KEYS_DEF   = 512;
    localparam int MAX_COMBOS_DEF = 64;

    // contexts at or above this are refused at load time
    localparam int MAX_CONTEXTS = 8;

    // field widths
    localparam int KEY_W  = 9;
    localparam int CTX_W  = 3;
    localparam int MAP_W  = 6;
    localparam int SLOT_W = 6;
    localparam int TS_W   = 32;
    localparam int CNT_W  = 7;
    localparam int NKEYS_PER_ENTRY = 4;

    // operation codes of an input beat
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // one chord table entry
    typedef struct packed {
        logic [NKEYS_PER_ENTRY-1:0][KEY_W-1:0] keys;
        logic [CTX_W-1:0]                      context_id;
        logic [MAP_W-1:0]                      mapping_id;
    } kcm_entry_t;

    localparam int ENTRY_W = $bits(kcm_entry_t);

endpackage

[sv/key_chord_matcher_core.sv]
// ---------------------------------------------------------------------------
// key_chord_matcher_core
// pressed-key tracker with a loadable chord table, reporting every chord
// completed or released by a key event
// ---------------------------------------------------------------------------
// The block keeps one pressed bit per key code in a key-state memory and up
// to MAX_COMBOS chords of four key codes each in a table memory. A load beat
// (operation = 1) writes one table slot unless its index or context is out
// of range. A key beat that is an auto-repeat is dropped. Any other key
// beat first marks its trigger key as pressed, then one sequencer walks
// slots 0 to min(combo_count, MAX_COMBOS)-1 through a two-stage read
// pipeline (table read, then four parallel key-state reads), one slot per
// cycle unless a new match finds the output register still stalled, and
// finally writes the real pressed value of the trigger. A key beat
// therefore holds in_stall from the set state through the scan and done
// states, which last longer while a new match finds the output register
// still stalled or the final match waits for it. Each match gives one
// result beat, in ascending slot order, with last set on the final match
// of the event. One match is held back until the next one (or the end of
// the walk) is known, so last is exact. Results wait in an output register,
// so a new input beat is taken while a result is still stalled. After reset
// the key-state memory is swept once, one key per cycle; in_stall stays high
// meanwhile while combo_count writes are taken as usual. Slots that were
// never loaded must not be scanned.
// ---------------------------------------------------------------------------
module key_chord_matcher_core
    import kcm_pkg::*;
#(
    parameter int NUM_KEYS   = NUM_KEYS_DEF,
    parameter int MAX_COMBOS = MAX_COMBOS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,

    // configuration
    input  logic              cfg_write_en,
    input  logic [CNT_W-1:0]  cfg_write_data,

    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic [KEY_W-1:0]  scancode,
    input  logic              pressed,
    input  logic              repeat_req,
    input  logic [TS_W-1:0]   timestamp,
    input  logic [SLOT_W-1:0] entry_index,
    input  logic [KEY_W-1:0]  entry_key0,
    input  logic [KEY_W-1:0]  entry_key1,
    input  logic [KEY_W-1:0]  entry_key2,
    input  logic [KEY_W-1:0]  entry_key3,
    input  logic [CTX_W-1:0]  entry_context,
    input  logic [MAP_W-1:0]  entry_mapping,

    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [KEY_W-1:0]  trigger_key,
    output logic              key_down,
    output logic [TS_W-1:0]   event_time,
    output logic [CTX_W-1:0]  context_id,
    output logic [MAP_W-1:0]  mapping_id,
    output logic [SLOT_W-1:0] matched_slot,
    output logic              last
);

    // key-state address width and table address width
    localparam int KA = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int SA = (MAX_COMBOS > 1) ? $clog2(MAX_COMBOS) : 1;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SET   = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DONE  = 5'b10000
    } kcm_state_t;

    // control registers
    kcm_state_t        state_reg, state_next;
    logic [KA-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  slot_reg, slot_next;
    logic              s1_vld_reg, s1_vld_next;
    logic              s2_vld_reg, s2_vld_next;
    logic              pend_vld_reg, pend_vld_next;
    logic              out_vld_reg, out_vld_next;

    // event payload
    logic [KEY_W-1:0]  trig_reg;
    logic              down_reg;
    logic [TS_W-1:0]   ts_reg;

    // pipeline payload
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [SLOT_W-1:0] s2_slot_reg;
    logic              s2_has_reg;
    logic [NKEYS_PER_ENTRY-1:0] s2_inr_reg;
    logic [CTX_W-1:0]  s2_ctx_reg;
    logic [MAP_W-1:0]  s2_map_reg;

    // held-back match
    logic [SLOT_W-1:0] pend_slot_reg;
    logic [CTX_W-1:0]  pend_ctx_reg;
    logic [MAP_W-1:0]  pend_map_reg;

    // output register
    logic [KEY_W-1:0]  out_trig_reg;
    logic              out_down_reg;
    logic [TS_W-1:0]   out_ts_reg;
    logic [CTX_W-1:0]  out_ctx_reg;
    logic [MAP_W-1:0]  out_map_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_last_reg;

    // memories
    logic              tbl_we;
    kcm_entry_t        tbl_wentry;
    logic [ENTRY_W-1:0] tbl_rdata;
    kcm_entry_t        tbl_rentry;

    logic              key_we;
    logic [KA-1:0]     key_waddr;
    logic              key_wdata;
    logic [KA-1:0]     key_raddr [NKEYS_PER_ENTRY];
    logic [NKEYS_PER_ENTRY-1:0] key_bit;

    // misc control
    logic              in_accept;
    logic              trig_inr;
    logic [CNT_W-1:0]  limit;
    logic              issue_act;
    logic              out_free;
    logic              s1_has;
    logic [NKEYS_PER_ENTRY-1:0] s1_inr;
    logic              s2_match;
    logic              advance;
    logic              drained;
    logic              push_mid;
    logic              push_last;
    logic              done_exit;

    // ------------------------------------------------------------------
    // handshake and limits
    // ------------------------------------------------------------------
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid & ~in_stall;
    assign trig_inr  = (32'(trig_reg) < 32'(NUM_KEYS));
    assign limit     = (32'(count_reg) > 32'(MAX_COMBOS)) ? CNT_W'(MAX_COMBOS) : count_reg;
    assign issue_act = (state_reg == ST_SCAN) && (slot_reg < limit);
    assign out_free  = ~out_vld_reg | ~out_stall;

    // ------------------------------------------------------------------
    // chord table, written straight from a load beat
    // ------------------------------------------------------------------
    assign tbl_we = in_accept && (operation == OP_LOAD)
                 && (32'(entry_index) < 32'(MAX_COMBOS))
                 && (32'(entry_context) < 32'(MAX_CONTEXTS));

    always_comb
    begin
        tbl_wentry.keys[0]    = entry_key0;
        tbl_wentry.keys[1]    = entry_key1;
        tbl_wentry.keys[2]    = entry_key2;
        tbl_wentry.keys[3]    = entry_key3;
        tbl_wentry.context_id = entry_context;
        tbl_wentry.mapping_id = entry_mapping;
    end

    kcm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_COMBOS)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (SA'(entry_index)),
        .wdata (tbl_wentry),
        .re    (advance),
        .raddr (SA'(slot_reg)),
        .rdata (tbl_rdata)
    );

    assign tbl_rentry = kcm_entry_t'(tbl_rdata);

    // ------------------------------------------------------------------
    // stage 1: table word is out, compare against trigger, issue key reads
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_has = 1'b0;
        for (int k = 0; k < NKEYS_PER_ENTRY; k++)
        begin
            if (tbl_rentry.keys[k] == trig_reg)
            begin
                s1_has = 1'b1;
            end
            // codes beyond the key range never read as pressed
            s1_inr[k]    = (32'(tbl_rentry.keys[k]) < 32'(NUM_KEYS));
            key_raddr[k] = KA'(tbl_rentry.keys[k]);
        end
    end

    // key-state write port, shared by the sweep and the event sequence
    always_comb
    begin
        key_we    = 1'b0;
        key_waddr = KA'(trig_reg);
        key_wdata = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                // key zero marks unused chord keys, so it starts pressed
                key_we    = 1'b1;
                key_waddr = clr_cnt_reg;
                key_wdata = (clr_cnt_reg == '0);
            end
            ST_SET:
            begin
                key_we = trig_inr;
            end
            ST_DONE:
            begin
                key_we    = trig_inr && done_exit;
                key_wdata = down_reg;
            end
            default:
            begin
                key_we = 1'b0;
            end
        endcase
    end

    // one copy of the key state per chord key position
    for (genvar g = 0; g < NKEYS_PER_ENTRY; g++)
    begin : g_key_ram
        kcm_ram #(
            .WIDTH (1),
            .DEPTH (NUM_KEYS)
        ) u_key_ram (
            .clk   (clk),
            .we    (key_we),
            .waddr (key_waddr),
            .wdata (key_wdata),
            .re    (advance),
            .raddr (key_raddr[g]),
            .rdata (key_bit[g])
        );
    end

    // ------------------------------------------------------------------
    // stage 2: key bits are out, decide the match
    // ------------------------------------------------------------------
    assign s2_match  = s2_vld_reg & s2_has_reg & (&(s2_inr_reg & key_bit));

    // a new match with a held match and a busy output freezes the walk;
    // the read ports hold their data, so both stages keep their words
    assign advance   = ~(s2_match & pend_vld_reg & ~out_free);
    assign drained   = ~issue_act & ~s1_vld_reg & ~s2_vld_reg;
    assign push_mid  = (state_reg == ST_SCAN) && s2_match && pend_vld_reg && out_free;
    assign push_last = (state_reg == ST_DONE) && pend_vld_reg && out_free;
    assign done_exit = (state_reg == ST_DONE) && (~pend_vld_reg || out_free);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        count_next    = count_reg;
        slot_next     = slot_reg;
        s1_vld_next   = s1_vld_reg;
        s2_vld_next   = s2_vld_reg;
        pend_vld_next = pend_vld_reg;

        if (cfg_write_en)
        begin
            count_next = cfg_write_data;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + KA'(1);
                if (clr_cnt_reg == KA'(NUM_KEYS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept && (operation == OP_KEY) && !repeat_req)
                begin
                    state_next = ST_SET;
                end
            end
            ST_SET:
            begin
                slot_next  = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    s1_vld_next = issue_act;
                    s2_vld_next = s1_vld_reg;
                    if (issue_act)
                    begin
                        slot_next = slot_reg + CNT_W'(1);
                    end
                    if (s2_match)
                    begin
                        pend_vld_next = 1'b1;
                    end
                end
                if (drained)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (push_last)
                begin
                    pend_vld_next = 1'b0;
                end
                if (done_exit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign out_vld_next = (push_mid || push_last) ? 1'b1 : (out_vld_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            count_reg    <= '0;
            slot_reg     <= '0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            count_reg    <= count_next;
            slot_reg     <= slot_next;
            s1_vld_reg   <= s1_vld_next;
            s2_vld_reg   <= s2_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // latch the key beat
        if (in_accept && (operation == OP_KEY))
        begin
            trig_reg <= scancode;
            down_reg <= pressed;
            ts_reg   <= timestamp;
        end

        if ((state_reg == ST_SCAN) && advance)
        begin
            s1_slot_reg <= SLOT_W'(slot_reg);
            s2_slot_reg <= s1_slot_reg;
            s2_has_reg  <= s1_has;
            s2_inr_reg  <= s1_inr;
            s2_ctx_reg  <= tbl_rentry.context_id;
            s2_map_reg  <= tbl_rentry.mapping_id;
            if (s2_match)
            begin
                pend_slot_reg <= s2_slot_reg;
                pend_ctx_reg  <= s2_ctx_reg;
                pend_map_reg  <= s2_map_reg;
            end
        end

        // the held match goes out once the next one, or the end, is known
        if (push_mid || push_last)
        begin
            out_trig_reg <= trig_reg;
            out_down_reg <= down_reg;
            out_ts_reg   <= ts_reg;
            out_ctx_reg  <= pend_ctx_reg;
            out_map_reg  <= pend_map_reg;
            out_slot_reg <= pend_slot_reg;
            out_last_reg <= push_last;
        end
    end

    assign out_valid    = out_vld_reg;
    assign trigger_key  = out_trig_reg;
    assign key_down     = out_down_reg;
    assign event_time   = out_ts_reg;
    assign context_id   = out_ctx_reg;
    assign mapping_id   = out_map_reg;
    assign matched_slot = out_slot_reg;
    assign last         = out_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // no match may still be held back once the event sequence is over
    a_no_pend_when_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_vld_reg
    ) else $error("held match left behind after an event");

    // the read pipeline only carries slots during the walk
    a_pipe_empty_outside_scan: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |-> (!s1_vld_reg && !s2_vld_reg)
    ) else $error("read pipeline busy outside the walk");

    // a reported slot always lies inside the scanned range
    a_slot_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (CNT_W'(out_slot_reg) < limit)
    ) else $error("result beat reports a slot outside the scanned range");

endmodule

[sv/kcm_ram.sv]
// ---------------------------------------------------------------------------
// kcm_ram
// generic single write port, single read port ram with registered read data;
// the read data register only loads while re is high
// ---------------------------------------------------------------------------
module kcm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
